[rtl/dct_pkg.sv]
package dct_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths fixed by the item format
    localparam int KIND_W     = 4;
    localparam int CODE_W     = 24;
    localparam int STATUS_W   = 8;
    localparam int ORIGIN_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CODE_W-1:0]   GROUP_ALL      = 24'hFF_FFFF;
    localparam logic [CODE_W-1:0]   EMISSION_BYTE  = 24'hFF_0000;
    localparam logic [CODE_W-1:0]   CODE_FREE      = 24'h00_0000;
    localparam logic [ORIGIN_W-1:0] ORIGIN_PRIMARY = 2'd0;
    localparam int                  CONFIRMED_BIT  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMISSION_ONLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN        = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE     = 4'd0,
        KIND_QUERY      = 4'd1,
        KIND_CLEAR      = 4'd2,
        KIND_SET_REC    = 4'd3,
        KIND_SET_SUPP   = 4'd4,
        KIND_ARM        = 4'd5,
        KIND_COUNT_FILT = 4'd6,
        KIND_NEXT       = 4'd7,
        KIND_COUNT_CONF = 4'd8,
        KIND_CLEAR_ALL  = 4'd9
    } t_kind;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic                suppressed;
        logic                enabled;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

endpackage

[rtl/dct_in_if.sv]
interface dct_in_if;
    logic                          valid;
    logic                          ready;
    logic [dct_pkg::KIND_W-1:0]    kind;
    logic [dct_pkg::CODE_W-1:0]    dtc_code;
    logic [dct_pkg::STATUS_W-1:0]  dtc_status;
    logic [dct_pkg::ORIGIN_W-1:0]  origin;
    logic                          flag;

    modport source (output valid, kind, dtc_code, dtc_status, origin, flag, input ready);
    modport sink   (input valid, kind, dtc_code, dtc_status, origin, flag, output ready);
endinterface

[rtl/dct_out_if.sv]
interface dct_out_if;
    logic                          valid;
    logic                          ready;
    logic                          outcome;
    logic [dct_pkg::CODE_W-1:0]    found_code;
    logic [dct_pkg::STATUS_W-1:0]  found_status;
    logic [dct_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, outcome, found_code, found_status, entry_count, input ready);
    modport sink   (input valid, outcome, found_code, found_status, entry_count, output ready);
endinterface

[rtl/diagnostic_code_table_core.sv]
// Diagnostic trouble code table of ENTRIES slots (64 as built).
// Request channel i_req carries one operation per transfer (kind, dtc_code,
// dtc_status, origin, flag); response channel o_rsp returns exactly one result
// per request (outcome, found_code, found_status, entry_count), in order.
// Filter registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// no request is in flight; the filter reads them live at each count or step.
// Every request runs a linear sweep of the table through a single
// registered read port, one slot per cycle. The sweep covers ENTRIES slots
// for all kinds except next filtered, which sweeps from the filter cursor to
// the end. A new request is taken only once the sequencer is back in idle
// after the commit step, so the block works on one request at a time.
// The response sits in an output register, so the next request is taken while
// the previous response still waits; if the receiver stalls, the finished
// result is held in the commit step until the register frees up.
// Reset (synchronous, active low) frees every slot at once through per-slot
// valid bits, disarms the filter and zeroes the cursor and filter registers.
module diagnostic_code_table_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dct_in_if.sink                         i_req,
    dct_out_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [dct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dct_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dct_pkg::t_ctl_cmd ctl_cmd;
    dct_pkg::t_ctl_sts ctl_sts;
    logic              in_ready;

    // sequencer: idle, sweep, commit
    dct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .o_cmd      (ctl_cmd),
        .i_sts      (ctl_sts)
    );

    assign i_req.ready = in_ready;

    // table memory, filter state, sweep accumulators and response register
    dct_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctl_cmd),
        .o_sts          (ctl_sts),
        .i_kind         (i_req.kind),
        .i_code         (i_req.dtc_code),
        .i_status       (i_req.dtc_status),
        .i_origin       (i_req.origin),
        .i_flag         (i_req.flag),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_outcome      (o_rsp.outcome),
        .o_found_code   (o_rsp.found_code),
        .o_found_status (o_rsp.found_status),
        .o_entry_count  (o_rsp.entry_count)
    );

endmodule

[rtl/dct_ctrl.sv]
module dct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output dct_pkg::t_ctl_cmd o_cmd,
    input  dct_pkg::t_ctl_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_rd = 1'b1;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the result register can take the result
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/dct_datapath.sv]
module dct_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dct_pkg::t_ctl_cmd                 i_cmd,
    output dct_pkg::t_ctl_sts                 o_sts,
    input  logic [dct_pkg::KIND_W-1:0]        i_kind,
    input  logic [dct_pkg::CODE_W-1:0]        i_code,
    input  logic [dct_pkg::STATUS_W-1:0]      i_status,
    input  logic [dct_pkg::ORIGIN_W-1:0]      i_origin,
    input  logic                              i_flag,
    input  logic                              i_cfg_we,
    input  logic [dct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_outcome,
    output logic [dct_pkg::CODE_W-1:0]        o_found_code,
    output logic [dct_pkg::STATUS_W-1:0]      o_found_status,
    output logic [dct_pkg::COUNT_W-1:0]       o_entry_count
);

    // table storage; r_valid marks used slots, a slot not valid is free
    dct_pkg::t_entry                   r_mem [dct_pkg::ENTRIES];
    logic [dct_pkg::ENTRIES-1:0]       r_valid;

    // latched item
    dct_pkg::t_kind                    r_kind;
    logic [dct_pkg::CODE_W-1:0]        r_code;
    logic [dct_pkg::STATUS_W-1:0]      r_status;
    logic [dct_pkg::ORIGIN_W-1:0]      r_origin;
    logic                              r_flag;

    // filter
    logic [dct_pkg::STATUS_W-1:0]      r_flt_mask;
    logic                              r_flt_emis;
    logic [dct_pkg::ORIGIN_W-1:0]      r_flt_origin;
    logic                              r_armed;
    logic [dct_pkg::CNT_W-1:0]         r_cursor;

    // scan
    logic [dct_pkg::CNT_W-1:0]         r_addr;
    logic                              r_rd_en;
    logic                              r_rd_vld;
    logic [dct_pkg::IDX_W-1:0]         r_rd_idx;
    dct_pkg::t_entry                   r_rd_word;

    // scan accumulators
    logic                              r_hit;
    logic [dct_pkg::IDX_W-1:0]         r_hit_idx;
    dct_pkg::t_entry                   r_hit_word;
    logic                              r_free_found;
    logic [dct_pkg::IDX_W-1:0]         r_free_idx;
    logic [dct_pkg::CNT_W-1:0]         r_count;

    // result register
    logic                              r_out_valid;
    logic                              r_out_outcome;
    logic [dct_pkg::CODE_W-1:0]        r_out_code;
    logic [dct_pkg::STATUS_W-1:0]      r_out_status;
    logic [dct_pkg::COUNT_W-1:0]       r_out_count;

    logic                              scan_done;
    logic                              out_free;
    logic                              code_hit;
    logic                              flt_match;
    logic                              confirmed;
    logic                              sel_pred;
    logic                              cnt_pred;

    // commit decode
    logic                              n_outcome;
    logic [dct_pkg::CODE_W-1:0]        n_out_code;
    logic [dct_pkg::STATUS_W-1:0]      n_out_status;
    logic [dct_pkg::COUNT_W-1:0]       n_out_count;
    logic                              mem_we;
    logic [dct_pkg::IDX_W-1:0]         mem_waddr;
    dct_pkg::t_entry                   mem_wdata;
    logic                              valid_set;
    logic                              valid_clr_one;
    logic                              valid_clr_all;
    logic                              arm;
    logic                              cursor_we;
    logic [dct_pkg::CNT_W-1:0]         n_cursor;

    assign scan_done = (r_addr == dct_pkg::CNT_W'(dct_pkg::ENTRIES));
    assign out_free  = !r_out_valid || i_out_ready;
    assign o_sts     = '{scan_done: scan_done, out_free: out_free};

    // slot predicates on the word read last cycle
    assign code_hit  = r_rd_vld && (r_rd_word.code == r_code);
    assign confirmed = r_rd_vld && r_rd_word.status[dct_pkg::CONFIRMED_BIT];
    assign flt_match = r_rd_vld && !r_rd_word.suppressed
                       && (r_flt_origin == dct_pkg::ORIGIN_PRIMARY)
                       && ((r_rd_word.status & r_flt_mask) != '0)
                       && (!r_flt_emis
                           || ((r_rd_word.code & dct_pkg::EMISSION_BYTE) == '0));
    assign sel_pred  = (r_kind == dct_pkg::KIND_NEXT) ? flt_match : code_hit;
    assign cnt_pred  = (r_kind == dct_pkg::KIND_COUNT_FILT) ? flt_match : confirmed;

    always_comb begin
        n_outcome     = 1'b1;
        n_out_code    = '0;
        n_out_status  = '0;
        n_out_count   = '0;
        mem_we        = 1'b0;
        mem_waddr     = r_hit_idx;
        mem_wdata     = r_hit_word;
        valid_set     = 1'b0;
        valid_clr_one = 1'b0;
        valid_clr_all = 1'b0;
        arm           = 1'b0;
        cursor_we     = 1'b0;
        n_cursor      = r_cursor;
        unique case (r_kind) inside
            dct_pkg::KIND_UPDATE: begin
                if (r_code != dct_pkg::CODE_FREE) begin
                    if (r_hit) begin
                        mem_we           = 1'b1;
                        mem_wdata.status = r_status;
                        n_outcome        = 1'b0;
                    end else if (r_free_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_idx;
                        mem_wdata = '{code: r_code, status: r_status,
                                      suppressed: 1'b0, enabled: 1'b1};
                        valid_set = 1'b1;
                        n_outcome = 1'b0;
                    end
                end
            end
            dct_pkg::KIND_QUERY: begin
                if (r_hit && r_origin == dct_pkg::ORIGIN_PRIMARY) begin
                    n_out_status = r_hit_word.status;
                    n_outcome    = 1'b0;
                end
            end
            dct_pkg::KIND_CLEAR: begin
                if (r_code == dct_pkg::GROUP_ALL) begin
                    valid_clr_all = (r_origin == dct_pkg::ORIGIN_PRIMARY);
                    n_outcome     = 1'b0;
                end else if (r_hit && r_origin == dct_pkg::ORIGIN_PRIMARY) begin
                    valid_clr_one = 1'b1;
                    n_outcome     = 1'b0;
                end
            end
            dct_pkg::KIND_SET_REC, dct_pkg::KIND_SET_SUPP: begin
                if (r_hit) begin
                    mem_we = 1'b1;
                    if (r_kind == dct_pkg::KIND_SET_REC) begin
                        mem_wdata.enabled = r_flag;
                    end else begin
                        mem_wdata.suppressed = r_flag;
                    end
                    n_outcome = 1'b0;
                end
            end
            dct_pkg::KIND_ARM: begin
                arm       = 1'b1;
                n_outcome = 1'b0;
            end
            dct_pkg::KIND_COUNT_FILT: begin
                if (r_armed) begin
                    n_out_count = dct_pkg::COUNT_W'(r_count);
                    n_outcome   = 1'b0;
                end
            end
            dct_pkg::KIND_NEXT: begin
                if (r_armed) begin
                    cursor_we = 1'b1;
                    if (r_hit) begin
                        n_cursor     = dct_pkg::CNT_W'(r_hit_idx) + dct_pkg::CNT_W'(1);
                        n_out_code   = r_hit_word.code;
                        n_out_status = r_hit_word.status;
                        n_outcome    = 1'b0;
                    end else begin
                        n_cursor = dct_pkg::CNT_W'(dct_pkg::ENTRIES);
                    end
                end
            end
            dct_pkg::KIND_COUNT_CONF: begin
                n_out_count = dct_pkg::COUNT_W'(r_count);
                n_outcome   = 1'b0;
            end
            dct_pkg::KIND_CLEAR_ALL: begin
                valid_clr_all = 1'b1;
                n_outcome     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.scan_rd) begin
            r_rd_word <= r_mem[r_addr[dct_pkg::IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= dct_pkg::t_kind'(i_kind);
            r_code   <= i_code;
            r_status <= i_status;
            r_origin <= i_origin;
            r_flag   <= i_flag;
        end
        if (i_cmd.scan_rd) begin
            r_rd_vld <= r_valid[r_addr[dct_pkg::IDX_W-1:0]];
            r_rd_idx <= r_addr[dct_pkg::IDX_W-1:0];
        end
        if (r_rd_en && sel_pred && !r_hit) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_word <= r_rd_word;
        end
        if (r_rd_en && !r_rd_vld && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out_outcome <= n_outcome;
            r_out_code    <= n_out_code;
            r_out_status  <= n_out_status;
            r_out_count   <= n_out_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_flt_mask   <= '0;
            r_flt_emis   <= 1'b0;
            r_flt_origin <= '0;
            r_armed      <= 1'b0;
            r_cursor     <= '0;
            r_addr       <= '0;
            r_rd_en      <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dct_pkg::CFG_STATUS_MASK:   r_flt_mask   <= i_cfg_data;
                    dct_pkg::CFG_EMISSION_ONLY: r_flt_emis   <= i_cfg_data[0];
                    dct_pkg::CFG_ORIGIN:        r_flt_origin <= i_cfg_data[dct_pkg::ORIGIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            r_rd_en <= i_cmd.scan_rd;

            if (i_cmd.accept) begin
                // next filtered resumes at the cursor, everything else sweeps the table
                if (dct_pkg::t_kind'(i_kind) == dct_pkg::KIND_NEXT) begin
                    r_addr <= r_cursor;
                end else begin
                    r_addr <= '0;
                end
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_count      <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_addr <= r_addr + dct_pkg::CNT_W'(1);
                end
                if (r_rd_en) begin
                    if (sel_pred) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_rd_vld) begin
                        r_free_found <= 1'b1;
                    end
                    if (cnt_pred) begin
                        r_count <= r_count + dct_pkg::CNT_W'(1);
                    end
                end
            end

            if (i_cmd.commit) begin
                if (valid_clr_all) begin
                    r_valid <= '0;
                end else if (valid_clr_one) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end else if (valid_set) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (arm) begin
                    r_armed  <= 1'b1;
                    r_cursor <= '0;
                end else if (cursor_we) begin
                    r_cursor <= n_cursor;
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_found_code   = r_out_code;
    assign o_found_status = r_out_status;
    assign o_entry_count  = r_out_count;

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> out_free)
        else $error("result committed while the result register is occupied");

    a_no_read_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> !scan_done)
        else $error("table read issued beyond the last slot");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= dct_pkg::CNT_W'(dct_pkg::ENTRIES))
        else $error("filter cursor beyond the table end");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dct_pkg::CNT_W'(dct_pkg::ENTRIES))
        else $error("scan count exceeds the number of slots");

    a_clear_all_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_kind == dct_pkg::KIND_CLEAR_ALL) |=> (r_valid == '0))
        else $error("slots still in use after clear all");

endmodule

[dv/diagnostic_code_table_core_test.sv]
`timescale 1ns / 1ps

// Checks diagnostic_code_table_core against a cycle-free prediction of its
// table: every request transfer is applied to a private copy of the slots and
// the filter, and the response it must produce is queued until the matching
// response transfer arrives, oldest first.
module diagnostic_code_table_core_test;
    import dct_pkg::*;

    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int SEGMENTS       = 6;
    localparam int RANDOM_PER_SEG = 170;
    localparam int FILL_BURST     = 70;      // more distinct codes than slots
    localparam int WALK_STEPS     = 12;
    localparam int POOL           = 96;
    localparam int RX_HOLD_CYCLES = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic                KEY_OK          = 1'b0;
    localparam logic                KEY_FAIL        = 1'b1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 8'h50;
    localparam logic [KIND_W-1:0]   KIND_SPARE_LO   = 4'd10;
    localparam logic [KIND_W-1:0]   KIND_SPARE_HI   = 4'd15;
    localparam logic [CODE_W-1:0]   CODE_ONE        = 24'h00_0001;
    localparam logic [CODE_W-1:0]   CODE_MID        = 24'h12_3456;
    localparam logic [CODE_W-1:0]   CODE_ABSENT     = 24'hAB_CDEF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic [ORIGIN_W-1:0] origin;
        logic                flag;
    } t_request;

    typedef struct packed {
        logic                outcome;
        logic [CODE_W-1:0]   found_code;
        logic [STATUS_W-1:0] found_status;
        logic [COUNT_W-1:0]  entry_count;
    } t_response;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dct_in_if  req_if();
    dct_out_if rsp_if();

    diagnostic_code_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns period, first rising edge at 10 ns
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Private copy of the table, the filter and its registers
    // ------------------------------------------------------------------
    t_entry                dtc_slots [ENTRIES];
    logic [CNT_W-1:0]      filter_cursor;
    logic                  filter_armed;
    logic [STATUS_W-1:0]   cfg_status_mask;
    logic                  cfg_emission_only;
    logic [ORIGIN_W-1:0]   cfg_origin;

    t_request  request_backlog [$];     // items waiting for the driver
    t_response dtc_responses_due [$];   // predicted responses, oldest first
    logic [CODE_W-1:0] code_pool [POOL];

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    logic rx_hold = 1'b0;
    logic req_taken = 1'b0;
    t_request  next_req;
    t_response seen_rsp;
    t_response want_rsp;

    int cycle_count  = 0;
    int failures     = 0;
    int requests_in  = 0;
    int responses_ok = 0;
    int full_rejects = 0;
    int steps_found  = 0;
    int settings_run = 0;

    function automatic void wipe_slot(int i);
        dtc_slots[i].code       = CODE_FREE;
        dtc_slots[i].status     = STATUS_CLEARED;
        dtc_slots[i].suppressed = 1'b0;
        dtc_slots[i].enabled    = 1'b1;
    endfunction

    // Slot holding the code, or ENTRIES when there is none; code zero marks
    // a free slot and so never matches.
    function automatic int slot_of(logic [CODE_W-1:0] code);
        if (code == CODE_FREE) return ENTRIES;
        for (int i = 0; i < ENTRIES; i++) begin
            if (dtc_slots[i].code == code) return i;
        end
        return ENTRIES;
    endfunction

    // The filter reads its registers live at each count or step.
    function automatic logic passes_filter(int i);
        return dtc_slots[i].code != CODE_FREE && !dtc_slots[i].suppressed &&
               cfg_origin == ORIGIN_PRIMARY &&
               (dtc_slots[i].status & cfg_status_mask) != '0 &&
               (!cfg_emission_only || (dtc_slots[i].code & EMISSION_BYTE) == CODE_FREE);
    endfunction

    // Apply one request to the table copy and return the response it causes.
    function automatic t_response dtc_response(t_request rq);
        t_response rs;
        int slot;
        int hits;
        rs = '{outcome: KEY_FAIL, found_code: CODE_FREE, found_status: '0,
               entry_count: '0};
        hits = 0;
        case (rq.kind)
            KIND_UPDATE: begin
                if (rq.code != CODE_FREE) begin
                    slot = slot_of(rq.code);
                    if (slot == ENTRIES) begin
                        // new code takes the lowest free slot
                        for (int i = ENTRIES - 1; i >= 0; i--) begin
                            if (dtc_slots[i].code == CODE_FREE) slot = i;
                        end
                        if (slot < ENTRIES) dtc_slots[slot].code = rq.code;
                        else full_rejects++;
                    end
                    if (slot < ENTRIES) begin
                        dtc_slots[slot].status = rq.status;
                        rs.outcome = KEY_OK;
                    end
                end
            end
            KIND_QUERY: begin
                slot = slot_of(rq.code);
                if (slot < ENTRIES && rq.origin == ORIGIN_PRIMARY) begin
                    rs.found_status = dtc_slots[slot].status;
                    rs.outcome = KEY_OK;
                end
            end
            KIND_CLEAR: begin
                if (rq.code == GROUP_ALL) begin
                    // a foreign origin holds nothing, so nothing changes
                    if (rq.origin == ORIGIN_PRIMARY) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (dtc_slots[i].code != CODE_FREE) wipe_slot(i);
                        end
                    end
                    rs.outcome = KEY_OK;
                end else begin
                    slot = slot_of(rq.code);
                    if (slot < ENTRIES && rq.origin == ORIGIN_PRIMARY) begin
                        wipe_slot(slot);
                        rs.outcome = KEY_OK;
                    end
                end
            end
            KIND_SET_REC, KIND_SET_SUPP: begin
                slot = slot_of(rq.code);
                if (slot < ENTRIES) begin
                    if (rq.kind == KIND_SET_REC) dtc_slots[slot].enabled = rq.flag;
                    else dtc_slots[slot].suppressed = rq.flag;
                    rs.outcome = KEY_OK;
                end
            end
            KIND_ARM: begin
                filter_armed  = 1'b1;
                filter_cursor = '0;
                rs.outcome    = KEY_OK;
            end
            KIND_COUNT_FILT: begin
                if (filter_armed) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (passes_filter(i)) hits++;
                    end
                    rs.outcome = KEY_OK;
                end
            end
            KIND_NEXT: begin
                // the cursor stays at the end once the table is exhausted
                if (filter_armed) begin
                    while (filter_cursor < ENTRIES) begin
                        slot = filter_cursor;
                        filter_cursor++;
                        if (passes_filter(slot)) begin
                            rs.found_code   = dtc_slots[slot].code;
                            rs.found_status = dtc_slots[slot].status;
                            rs.outcome      = KEY_OK;
                            steps_found++;
                            break;
                        end
                    end
                end
            end
            KIND_COUNT_CONF: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (dtc_slots[i].code != CODE_FREE &&
                        dtc_slots[i].status[CONFIRMED_BIT]) hits++;
                end
                rs.outcome = KEY_OK;
            end
            KIND_CLEAR_ALL: begin
                for (int i = 0; i < ENTRIES; i++) wipe_slot(i);
                rs.outcome = KEY_OK;
            end
            default: begin
                // spare kinds leave everything alone and report not ok
            end
        endcase
        rs.entry_count = hits[COUNT_W-1:0];
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_req(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                      logic [STATUS_W-1:0] status,
                                      logic [ORIGIN_W-1:0] origin, logic flag);
        request_backlog.push_back('{kind, code, status, origin, flag});
    endfunction

    // Mostly codes from a shared pool, so that requests hit stored slots;
    // now and then a fully random code or the free code.
    function automatic t_request rand_request();
        t_request r;
        int roll;
        int pick;
        roll = $urandom_range(999);
        if (roll < 880) r.code = code_pool[$urandom_range(POOL - 1)];
        else if (roll < 960) r.code = CODE_W'($urandom);
        else r.code = CODE_FREE;
        r.status = STATUS_W'($urandom);
        r.origin = ($urandom_range(99) < 80) ? ORIGIN_PRIMARY : ORIGIN_W'($urandom);
        r.flag   = 1'($urandom);
        pick = $urandom_range(999);
        if (pick < 330) r.kind = KIND_UPDATE;
        else if (pick < 450) r.kind = KIND_QUERY;
        else if (pick < 530) r.kind = KIND_CLEAR;
        else if (pick < 535) begin
            r.kind = KIND_CLEAR;
            r.code = GROUP_ALL;
        end
        else if (pick < 590) r.kind = KIND_SET_REC;
        else if (pick < 660) r.kind = KIND_SET_SUPP;
        else if (pick < 700) r.kind = KIND_ARM;
        else if (pick < 760) r.kind = KIND_COUNT_FILT;
        else if (pick < 900) r.kind = KIND_NEXT;
        else if (pick < 960) r.kind = KIND_COUNT_CONF;
        else if (pick < 963) r.kind = KIND_CLEAR_ALL;
        else r.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        return r;
    endfunction

    // Write one filter register; the caller lowers the enable afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_STATUS_MASK:   cfg_status_mask   = data;
            CFG_EMISSION_ONLY: cfg_emission_only = data[0];
            CFG_ORIGIN:        cfg_origin        = data[ORIGIN_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every item has been handed over and answered, then let
    // the block go quiet before returning.
    task automatic settle();
        while (request_backlog.size() != 0 || req_if.valid ||
               dtc_responses_due.size() != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: advance to the next item only after a transfer or while idle
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_req = request_backlog.pop_front();
                req_if.kind       <= next_req.kind;
                req_if.dtc_code   <= next_req.code;
                req_if.dtc_status <= next_req.status;
                req_if.origin     <= next_req.origin;
                req_if.flag       <= next_req.flag;
                req_if.valid      <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off while rx_hold is set
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check response transfers first, then predict from request
    // transfers taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            seen_rsp = '{rsp_if.outcome, rsp_if.found_code, rsp_if.found_status,
                         rsp_if.entry_count};
            if (dtc_responses_due.size() == 0) begin
                if (failures < MAX_REPORTS)
                    $display("[%0t] unexpected response: outcome %0d code %h status %h count %0d",
                             $realtime, seen_rsp.outcome, seen_rsp.found_code,
                             seen_rsp.found_status, seen_rsp.entry_count);
                failures++;
            end else begin
                want_rsp = dtc_responses_due.pop_front();
                if (seen_rsp.outcome !== want_rsp.outcome ||
                    seen_rsp.found_code !== want_rsp.found_code ||
                    seen_rsp.found_status !== want_rsp.found_status ||
                    seen_rsp.entry_count !== want_rsp.entry_count) begin
                    if (failures < MAX_REPORTS) begin
                        $display("[%0t] response %0d mismatch",
                                 $realtime, responses_ok + failures);
                        $display("    expected outcome %0d code %h status %h count %0d",
                                 want_rsp.outcome, want_rsp.found_code,
                                 want_rsp.found_status, want_rsp.entry_count);
                        $display("    actual   outcome %0d code %h status %h count %0d",
                                 seen_rsp.outcome, seen_rsp.found_code,
                                 seen_rsp.found_status, seen_rsp.entry_count);
                    end
                    failures++;
                end else begin
                    responses_ok++;
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            dtc_responses_due.push_back(dtc_response('{req_if.kind, req_if.dtc_code,
                                                       req_if.dtc_status, req_if.origin,
                                                       req_if.flag}));
            requests_in++;
        end
    end

    // Watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d responses still due",
                     cycle_count, dtc_responses_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        logic [STATUS_W-1:0] seg_mask;
        logic                seg_emission;
        logic [ORIGIN_W-1:0] seg_origin;

        // hold every input at a known value from time zero
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.kind       = '0;
        req_if.dtc_code   = '0;
        req_if.dtc_status = '0;
        req_if.origin     = '0;
        req_if.flag       = 1'b0;
        rsp_if.ready      = 1'b0;

        for (int i = 0; i < ENTRIES; i++) wipe_slot(i);
        filter_cursor     = '0;
        filter_armed      = 1'b0;
        cfg_status_mask   = '0;
        cfg_emission_only = 1'b0;
        cfg_origin        = ORIGIN_PRIMARY;

        // distinct codes: the middle byte carries the pool index plus one; even
        // entries have a zero top byte so that the emission filter passes them
        for (int i = 0; i < POOL; i++) begin
            if (i % 2 == 0) code_pool[i] = {8'h00, 8'(i + 1), 8'($urandom)};
            else code_pool[i] = {8'($urandom_range(1, 255)), 8'(i + 1), 8'($urandom)};
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();

            // idling plan: receiver sparse first, then sender, then neither
            if (seg < 2) begin
                send_gap_pct = 26;
                recv_gap_pct = 57;
            end else if (seg < 4) begin
                send_gap_pct = 57;
                recv_gap_pct = 26;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            // filter settings, the extremes among them
            case (seg)
                0: begin
                    seg_mask = 8'hFF; seg_emission = 1'b0; seg_origin = ORIGIN_PRIMARY;
                end
                1: begin
                    seg_mask = 8'h00; seg_emission = 1'b0; seg_origin = ORIGIN_PRIMARY;
                end
                2: begin
                    seg_mask = 8'h08; seg_emission = 1'b1; seg_origin = ORIGIN_PRIMARY;
                end
                3: begin
                    seg_mask = 8'hFF; seg_emission = 1'b0; seg_origin = 2'd3;
                end
                4: begin
                    seg_mask = STATUS_W'($urandom); seg_emission = 1'($urandom);
                    seg_origin = ORIGIN_PRIMARY;
                end
                default: begin
                    seg_mask = 8'h01; seg_emission = 1'b1; seg_origin = 2'd1;
                end
            endcase
            write_reg(CFG_STATUS_MASK, seg_mask);
            write_reg(CFG_EMISSION_ONLY, {{(CFG_DATA_W - 1){1'b0}}, seg_emission});
            write_reg(CFG_ORIGIN, {{(CFG_DATA_W - ORIGIN_W){1'b0}}, seg_origin});
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            settings_run++;

            if (seg == 0) begin
                // directed: empty table, unarmed filter, code zero, the
                // all-ones code, existing and new codes, foreign origins,
                // exhausted filter, group clears and spare kinds
                queue_req(KIND_COUNT_CONF, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_NEXT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_COUNT_FILT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_UPDATE, CODE_FREE, 8'hFF, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_UPDATE, GROUP_ALL, 8'hFF, 2'd3, 1'b1);
                queue_req(KIND_UPDATE, CODE_ONE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_UPDATE, CODE_MID, 8'h08, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_UPDATE, CODE_ONE, 8'h09, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_QUERY, CODE_ONE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_QUERY, CODE_ONE, 8'h00, 2'd3, 1'b0);
                queue_req(KIND_QUERY, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_SET_REC, CODE_ONE, 8'h00, 2'd2, 1'b0);
                queue_req(KIND_SET_REC, CODE_ABSENT, 8'h00, ORIGIN_PRIMARY, 1'b1);
                queue_req(KIND_SET_SUPP, CODE_MID, 8'h00, ORIGIN_PRIMARY, 1'b1);
                queue_req(KIND_ARM, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_COUNT_FILT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                repeat (3) queue_req(KIND_NEXT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_COUNT_CONF, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_CLEAR, CODE_ONE, 8'h00, 2'd2, 1'b0);
                queue_req(KIND_CLEAR, CODE_ONE, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_CLEAR, GROUP_ALL, 8'h00, 2'd1, 1'b0);
                queue_req(KIND_CLEAR, GROUP_ALL, 8'h00, ORIGIN_PRIMARY, 1'b0);
                queue_req(KIND_SPARE_LO, CODE_MID, 8'hFF, ORIGIN_PRIMARY, 1'b1);
                queue_req(KIND_SPARE_HI, CODE_MID, 8'hFF, ORIGIN_PRIMARY, 1'b1);
                queue_req(KIND_CLEAR_ALL, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
            end

            // hold the receiver off while the sender keeps offering, so the
            // output register and the commit step both fill and stall input
            if (seg == 4) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end

            // fill past capacity, then walk the filter over the full table
            for (int i = 0; i < FILL_BURST; i++)
                queue_req(KIND_UPDATE, code_pool[i], STATUS_W'($urandom),
                          ORIGIN_W'($urandom), 1'($urandom));
            for (int i = 0; i < 8; i++)
                queue_req(KIND_SET_SUPP, code_pool[$urandom_range(FILL_BURST - 1)],
                          8'h00, ORIGIN_PRIMARY, 1'($urandom));
            queue_req(KIND_ARM, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
            queue_req(KIND_COUNT_FILT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
            repeat (WALK_STEPS) queue_req(KIND_NEXT, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);
            queue_req(KIND_COUNT_CONF, CODE_FREE, 8'h00, ORIGIN_PRIMARY, 1'b0);

            for (int i = 0; i < RANDOM_PER_SEG; i++) request_backlog.push_back(rand_request());
        end

        settle();
        failures += dtc_responses_due.size();

        $display("covered %0d requests under %0d filter settings, %0d responses matched",
                 requests_in, settings_run, responses_ok);
        $display("table-full rejects seen: %0d, filter steps that returned a code: %0d",
                 full_rejects, steps_found);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d failures", failures);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
